>>> hw/rtl/mwns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwns_pkg
// Shared types and codes for the weighted next-state stepper: beat structs,
// item modes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package mwns_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [7:0]  weight;
    logic [15:0] random_fraction;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  next_state;
    logic [15:0] gate_onehot;
    logic        moved;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_SUM_LAST,
    ST_MUL,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic item_wr;
    logic rd_en;
    logic scan;
    logic load_target;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       sum_zero;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/mwns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwns_ctrl
// Sequencer: clears the weight memory after reset, then runs each item as a
// write, a row sum then (if nonzero) a prefix scan, or a direct result.
// ----------------------------------------------------------------------------
module mwns_ctrl import mwns_pkg::*; #(
  parameter int NUM_STATES = 16,
  localparam int AW = $clog2(NUM_STATES * NUM_STATES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] cnt
);

  localparam logic [AW-1:0] CNT_CLEAR_LAST = AW'(NUM_STATES * NUM_STATES - 1);
  localparam logic [AW-1:0] CNT_ROW_LAST   = AW'(NUM_STATES - 1);

  ctrl_state_t   state, state_next;
  logic [AW-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (cnt == CNT_CLEAR_LAST) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (stat.in_mode)
            MODE_WRITE: state_next = ST_WRITE;
            MODE_STEP:  state_next = ST_SUM;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.item_wr = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_SUM: begin
        cmd.rd_en = 1'b1;
        if (cnt == CNT_ROW_LAST) begin
          cnt_next   = '0;
          state_next = ST_SUM_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      // last read of the row lands in the accumulator here
      ST_SUM_LAST: state_next = ST_MUL;
      ST_MUL: begin
        cmd.load_target = 1'b1;
        state_next      = stat.sum_zero ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        if (cnt == CNT_ROW_LAST) begin
          cnt_next   = '0;
          state_next = ST_SCAN_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCAN_LAST: state_next = ST_FINISH;
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/mwns_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwns_datapath
// Weight memory, row accumulator, target multiplier, prefix compare, current
// state and the output register.
// ----------------------------------------------------------------------------
module mwns_datapath import mwns_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int WEIGHT_BITS = 8,
  parameter int RANDOM_BITS = 16,
  localparam int AW = $clog2(NUM_STATES * NUM_STATES)
) (
  input  logic          clk,
  input  logic          rst,
  input  in_beat_t      in_data,
  input  dp_cmd_t       cmd,
  input  logic [AW-1:0] cnt,
  output dp_stat_t      stat,
  input  logic          out_ready,
  output logic          out_valid,
  output out_beat_t     out_data
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int DEPTH = NUM_STATES * NUM_STATES;
  localparam int SUMW  = WEIGHT_BITS + SW;
  localparam int TW    = SUMW + RANDOM_BITS;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata;

  in_beat_t         item;
  logic [SW-1:0]    cur;
  logic [SUMW-1:0]  acc, acc_sum;
  logic [TW-1:0]    target;
  logic             found, hit;
  logic [SW-1:0]    sel;
  logic             data_valid, data_scan;
  logic [SW-1:0]    data_col;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_in_range;
  logic [RANDOM_BITS-1:0] rnd;
  logic [SW-1:0]    state_new;
  out_beat_t        out_next;

  assign wr_in_range = (32'(item.row) < NUM_STATES) && (32'(item.column) < NUM_STATES);
  assign wr_addr     = AW'(32'(item.row) * NUM_STATES + 32'(item.column));
  assign rd_addr     = AW'(32'(cur) * NUM_STATES + 32'(cnt[SW-1:0]));
  assign rnd         = RANDOM_BITS'(item.random_fraction);

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[cnt] <= '0;
    end else if (cmd.item_wr && wr_in_range) begin
      mem[wr_addr] <= WEIGHT_BITS'(item.weight);
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign acc_sum = acc + SUMW'(rdata);
  // prefix * 2^RANDOM_BITS > random * sum
  assign hit = data_valid && data_scan && !found &&
               ({acc_sum, {RANDOM_BITS{1'b0}}} > target);

  always_comb begin
    priority if (item.mode == MODE_RESET) begin
      state_new = '0;
    end else if (item.mode == MODE_STEP && found) begin
      state_new = sel;
    end else begin
      state_new = cur;
    end
    out_next.next_state  = 4'(state_new);
    out_next.gate_onehot = 16'd1 << state_new;
    out_next.moved       = (item.mode == MODE_STEP) && found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      out_valid  <= 1'b0;
      data_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      data_valid <= cmd.rd_en;
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
      if (cmd.out_load) begin
        cur <= state_new;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_scan <= cmd.scan;
    data_col  <= cnt[SW-1:0];
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.accept || cmd.load_target) begin
      acc <= '0;
    end else if (data_valid) begin
      acc <= acc_sum;
    end
    if (cmd.load_target) begin
      target <= TW'(rnd) * TW'(acc);
    end
    if (hit) begin
      sel <= data_col;
    end
    if (cmd.out_load) begin
      out_data <= out_next;
    end
  end

  assign stat.in_mode  = in_data.mode;
  assign stat.sum_zero = (acc == '0);
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> hw/rtl/markov_weighted_next_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_weighted_next_state
// Markov chain stepper with roulette-wheel choice of the next state.
// ----------------------------------------------------------------------------
// After reset the weight memory is swept to zero, one entry per cycle, over
// all NUM_STATES*NUM_STATES entries; no item is taken during that time. Items
// are taken one at a time. A step reads the current row from the single-port
// weight memory twice, once to sum it and once to walk the prefix sums; a step
// on an all-zero row skips the prefix walk. One result beat per item; the
// output register lets the next item be accepted while a result still waits,
// and an item stalls in its last cycle until that register is free.
// ----------------------------------------------------------------------------
module markov_weighted_next_state import mwns_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int WEIGHT_BITS = 8,
  parameter int RANDOM_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int AW = $clog2(NUM_STATES * NUM_STATES);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] cnt;

  mwns_ctrl #(
    .NUM_STATES (NUM_STATES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  mwns_datapath #(
    .NUM_STATES  (NUM_STATES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .cnt       (cnt),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/mwns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwns_checker
// Port-level checks for the stepper, bound to the top level.
// ----------------------------------------------------------------------------
module mwns_checker import mwns_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // gate mask agrees with the reported state
  a_gate_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_data.gate_onehot) &&
                  out_data.gate_onehot[out_data.next_state])
    else $error("gate mask does not match next state");

  // memory sweep keeps the input closed right after reset
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input open during memory clear");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accepting a beat");

endmodule

bind markov_weighted_next_state mwns_checker u_checker (.*);

>>> verif/markov_weighted_next_state_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_weighted_next_state_test
// Drives weight writes, steps, state resets and unused-mode beats into the
// Markov stepper. A scoreboard class keeps its own copy of the weight table and
// current state, works out each result beat on input acceptance, and compares
// the output beats in order. Runs through several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module markov_weighted_next_state_test;
  import mwns_pkg::*;

  localparam int STATES       = 16;
  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BEATS  = 320;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class step_scoreboard;
    logic [7:0] weights [STATES][STATES];
    logic [3:0] state;
    out_beat_t  pending [$];
    int errors, checked;
    int writes, steps, moves, self_moves, zero_sum_steps, resets, unused;

    function new();
      foreach (weights[r, c]) weights[r][c] = '0;
      state = '0;
      errors = 0;
      checked = 0;
      writes = 0;
      steps = 0;
      moves = 0;
      self_moves = 0;
      zero_sum_steps = 0;
      resets = 0;
      unused = 0;
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t r;
      logic [3:0] src;
      longint unsigned total, running, target;
      bit moved;
      moved = 1'b0;
      src = state;
      case (b.mode)
        MODE_WRITE: begin
          weights[b.row][b.column] = b.weight;
          writes++;
        end
        MODE_RESET: begin
          state = '0;
          resets++;
        end
        MODE_STEP: begin
          steps++;
          total = 0;
          running = 0;
          for (int k = 0; k < STATES; k++) total += weights[src][k];
          if (total == 0) begin
            zero_sum_steps++;
          end else begin
            target = longint'(b.random_fraction) * total;
            // first column whose prefix sum exceeds random times sum
            for (int k = 0; k < STATES; k++) begin
              running += weights[src][k];
              if (!moved && ((running << FRAC_BITS) > target)) begin
                state = k[3:0];
                moved = 1'b1;
              end
            end
            if (moved) moves++;
            if (moved && state == src) self_moves++;
          end
        end
        default: unused++;
      endcase
      r.next_state  = state;
      r.gate_onehot = 16'd1 << state;
      r.moved       = moved;
      pending.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.next_state !== want.next_state) begin
        $display("%0t: next_state expected %0d actual %0d", $time,
                 want.next_state, got.next_state);
        errors++;
      end
      if (got.gate_onehot !== want.gate_onehot) begin
        $display("%0t: gate_onehot expected %h actual %h", $time,
                 want.gate_onehot, got.gate_onehot);
        errors++;
      end
      if (got.moved !== want.moved) begin
        $display("%0t: moved expected %b actual %b", $time, want.moved, got.moved);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  step_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;
  int n_sent;

  markov_weighted_next_state uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 sb.pending.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_beat_t make_item(logic [1:0] mode, logic [3:0] row,
                                         logic [3:0] column, logic [7:0] weight,
                                         logic [15:0] frac);
    in_beat_t b;
    b.mode = mode;
    b.row = row;
    b.column = column;
    b.weight = weight;
    b.random_fraction = frac;
    return b;
  endfunction

  function automatic in_beat_t random_item();
    in_beat_t b;
    int unsigned pick;
    b = make_item(2'($urandom_range(3)), 4'($urandom), 4'($urandom), 8'($urandom),
                  16'($urandom));
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) b.random_fraction = $urandom_range(1) ? 16'hffff : 16'h0000;
    if (pick < 40) begin
      b.mode = MODE_WRITE;
      // bias writes toward the row that the next step will read
      if (pick < 20) b.row = sb.state;
      case ($urandom_range(9))
        0, 1:    b.weight = 8'd0;
        2:       b.weight = 8'd255;
        default: ;
      endcase
    end else if (pick < 88) begin
      b.mode = MODE_STEP;
    end else if (pick < 95) begin
      b.mode = MODE_RESET;
    end else begin
      b.mode = MODE_UNUSED;
    end
    return b;
  endfunction

  task automatic send_item(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // zero the whole current row, then step on it
  task automatic wipe_and_step();
    logic [3:0] src;
    src = sb.state;
    for (int c = 0; c < STATES; c++) send_item(make_item(MODE_WRITE, src, 4'(c), 8'd0, 16'($urandom)));
    send_item(make_item(MODE_STEP, 4'($urandom), 4'($urandom), 8'($urandom), 16'($urandom)));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed beats
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'h0000)); // zero row sum
    send_item(make_item(MODE_UNUSED, 4'd15, 4'd15, 8'd255, 16'hffff));
    send_item(make_item(MODE_WRITE,  4'd0,  4'd0,  8'd255, 16'h0000));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'hffff)); // lands on itself
    send_item(make_item(MODE_WRITE,  4'd0,  4'd15, 8'd1,   16'hffff));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'hffff)); // tiny last slice
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'h8000)); // row 15 empty
    send_item(make_item(MODE_WRITE,  4'd15, 4'd3,  8'h55,  16'h0000));
    send_item(make_item(MODE_WRITE,  4'd15, 4'd7,  8'haa,  16'h0000));
    send_item(make_item(MODE_WRITE,  4'd15, 4'd15, 8'h80,  16'h0000));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'h0000)); // first nonzero col
    send_item(make_item(MODE_RESET,  4'd9,  4'd9,  8'h5a,  16'h5555));
    send_item(make_item(MODE_WRITE,  4'd0,  4'd0,  8'd0,   16'h0000));
    send_item(make_item(MODE_WRITE,  4'd0,  4'd15, 8'd0,   16'h0000));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'h8000)); // row 0 empty again
    send_item(make_item(MODE_WRITE,  4'd0,  4'd8,  8'haa,  16'h0000));
    send_item(make_item(MODE_WRITE,  4'd8,  4'd15, 8'h55,  16'h0000));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'h5555));
    send_item(make_item(MODE_STEP,   4'd0,  4'd0,  8'd0,   16'haaaa));
    send_item(make_item(MODE_RESET,  4'd0,  4'd0,  8'd0,   16'h0000));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (phase == 0 && i == 150) hold_req = 1'b1;
        if ($urandom_range(99) < 2) wipe_and_step();
        else send_item(random_item());
      end
      // sender pauses until every pending result is back
      drain();
    end

    repeat (50) @(posedge clk);
    $display("sent %0d beats, checked %0d results: %0d writes, %0d resets, %0d unused",
             n_sent, sb.checked, sb.writes, sb.resets, sb.unused);
    $display("steps %0d: %0d moved (%0d back to same state), %0d on empty rows",
             sb.steps, sb.moves, sb.self_moves, sb.zero_sum_steps);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
